@@ sv/nlr_pkg.sv @@
// ----------------------------------------------------------------------------
// nlr_pkg
// Shared types, constants and fixed-point helpers for the normalized
// Legendre recurrence block.
// ----------------------------------------------------------------------------
package nlr_pkg;

    localparam int unsigned CFG_W      = 5;
    localparam int unsigned MAX_DEGREE = 31;

    localparam logic [0:0] REG_ORDER      = 1'b0;
    localparam logic [0:0] REG_MAX_DEGREE = 1'b1;

    localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;

    typedef enum logic [0:0] {
        ITER_DIV,
        ITER_SQRT
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root_quot;
    } iter_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_Z0,
        ST_Z1,
        ST_DMU2,
        ST_DS,
        ST_DQ,
        ST_DQ_GO,
        ST_DQ_WT,
        ST_DR_GO,
        ST_DR_WT,
        ST_DRS,
        ST_DP2,
        ST_DC_GO,
        ST_DC_WT,
        ST_DA,
        ST_DA2,
        ST_DCA,
        ST_DP1,
        ST_DE0,
        ST_DE1,
        ST_SMA,
        ST_SA,
        ST_SKA,
        ST_SC2,
        ST_SNUM,
        ST_SC1_GO,
        ST_SC1_WT,
        ST_SDIV_GO,
        ST_SDIV_WT,
        ST_SEMIT
    } seq_state_t;

    // shift right, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input logic [5:0] sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + (64'd1 << (sh - 6'd1))) >> sh;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat_q30(input logic signed [63:0] v);
        if (v > 64'sd1073741824) begin
            return ONE_Q30;
        end else if (v < -64'sd1073741824) begin
            return NEG_ONE_Q30;
        end
        return v[31:0];
    endfunction

endpackage

@@ sv/nlr_ram.sv @@
// ----------------------------------------------------------------------------
// nlr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/nlr_iter.sv @@
// ----------------------------------------------------------------------------
// nlr_iter
// Shared iterative unit: 64/32 restoring divide with overflow clamp, or
// 64-bit integer square root. One bit per cycle.
// ----------------------------------------------------------------------------
module nlr_iter (
    input  logic              aclk,
    input  logic              aresetn,
    input  nlr_pkg::iter_req_t req,
    input  logic [63:0]       num,
    input  logic [31:0]       den,
    output nlr_pkg::iter_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    nlr_pkg::iter_mode_t mode_reg;
    logic [5:0]        count_reg;
    logic [63:0]       rem_reg;
    logic [63:0]       aux_reg;
    logic [63:0]       res_reg;
    logic [63:0]       den_sh;
    logic [63:0]       trial;
    logic              take;

    assign den_sh = {1'b0, den, 31'b0};

    always_comb begin
        trial = (mode_reg == nlr_pkg::ITER_SQRT) ? (res_reg + aux_reg) : aux_reg;
        take  = (rem_reg >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && count_reg == 6'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.mode;
            rem_reg  <= num;
            if (req.mode == nlr_pkg::ITER_SQRT) begin
                aux_reg   <= 64'd1 << 62;
                res_reg   <= 64'd0;
                count_reg <= 6'd32;
            end else if (num >= den_sh) begin
                aux_reg   <= den_sh;
                res_reg   <= 64'd1 << 31;
                count_reg <= 6'd0;
            end else begin
                aux_reg   <= den_sh;
                res_reg   <= 64'd0;
                count_reg <= 6'd32;
            end
        end else if (busy_reg && count_reg != 6'd0) begin
            count_reg <= count_reg - 6'd1;
            if (mode_reg == nlr_pkg::ITER_SQRT) begin
                if (take) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + aux_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                aux_reg <= aux_reg >> 2;
            end else begin
                if (take) begin
                    rem_reg <= rem_reg - trial;
                end
                res_reg <= {res_reg[62:0], take};
                aux_reg <= aux_reg >> 1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.root_quot = res_reg[31:0];

endmodule

@@ sv/normalized_legendre_recurrence_top.sv @@
// ----------------------------------------------------------------------------
// normalized_legendre_recurrence_top
// Normalized associated Legendre values Y_l^m for one angle per transaction.
//
// Input channel (s_*): one angle slot and cosine per transaction. Result
// channel (m_*): one transaction per degree l = order .. max_degree, with
// m_last on the final one; a bad configuration gives one transaction with
// m_error set. Registers order (0x0) and max_degree (0x4) sit on the APB port
// and must be written only while the block is idle; the block does not enforce
// it. One angle is processed at a time. For order 0 the first result is
// emitted from the state after acceptance; for higher orders the diagonal
// chain first runs two square roots and one divide. Each further degree runs
// a square root and a divide for higher orders and a divide for order 0 on
// the shared one-bit-per-cycle divide and square-root unit. The stored diagonal
// per slot sits in a RAM read once per angle and written if no config error.
// A single output register holds each result; while the receiver stalls the
// sequencer waits on it. Reset clears the registers to order 0 and
// max_degree 31 and empties the output; the diagonal RAM is not cleared.
// ----------------------------------------------------------------------------
module normalized_legendre_recurrence_top #(
    parameter int MAX_ANGLES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_angle_index,
    input  logic signed [31:0] s_angle_cosine,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_degree,
    output logic signed [31:0] m_poly_value,
    output logic               m_last,
    output logic               m_error
);

    localparam int ADDR_W = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;

    logic [4:0] order_reg;
    logic [4:0] max_degree_reg;
    logic [4:0] lmax_cfg;
    logic       cfg_err;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg      <= 5'd0;
            max_degree_reg <= 5'd31;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                nlr_pkg::REG_ORDER:      order_reg      <= pwdata[4:0];
                nlr_pkg::REG_MAX_DEGREE: max_degree_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            nlr_pkg::REG_ORDER: prdata = {27'd0, order_reg};
            default:            prdata = {27'd0, max_degree_reg};
        endcase
    end

    assign lmax_cfg = ({1'b0, max_degree_reg} > 6'(nlr_pkg::MAX_DEGREE))
                      ? 5'(nlr_pkg::MAX_DEGREE) : max_degree_reg;
    assign cfg_err  = ({1'b0, order_reg} + 6'd1) > {1'b0, lmax_cfg};

    logic [ADDR_W-1:0] slot_lut [64];

    for (genvar gi = 0; gi < 64; gi++) begin : g_slot
        assign slot_lut[gi] = ADDR_W'(gi % MAX_ANGLES);
    end

    nlr_pkg::seq_state_t state_reg, state_next;

    logic signed [31:0] mu_reg, p1_reg, p2_reg, stored_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic [31:0]        c1_reg, c2_reg;
    logic [4:0]         l_reg, m_reg, lmax_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic               neg_reg;

    logic signed [31:0] mu_clamped;
    logic               accept;
    logic               out_free;
    logic               m_pos;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_prod;
    logic               mul_en;

    nlr_pkg::iter_req_t iter_req;
    nlr_pkg::iter_rsp_t iter_rsp;
    logic [63:0]        iter_num;
    logic [31:0]        iter_den;

    logic               ram_we;
    logic [31:0]        ram_rdata;
    logic signed [31:0] diag_val;

    logic               emit;
    logic [4:0]         emit_degree;
    logic signed [31:0] emit_value;
    logic               emit_last;
    logic               emit_error;

    logic [63:0]        acc_mag;
    logic [63:0]        div_num;
    logic [10:0]        lm_prod;
    logic signed [63:0] quot_signed;

    logic               m_valid_reg;
    logic [4:0]         m_degree_reg;
    logic signed [31:0] m_poly_value_reg;
    logic               m_last_reg;
    logic               m_error_reg;

    assign s_ready  = (state_reg == nlr_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_pos    = (m_reg != 5'd0);

    assign mu_clamped = (s_angle_cosine > nlr_pkg::ONE_Q30) ? nlr_pkg::ONE_Q30 :
                        (s_angle_cosine < nlr_pkg::NEG_ONE_Q30) ? nlr_pkg::NEG_ONE_Q30 :
                        s_angle_cosine;

    assign mul_prod = mul_a * mul_b;
    assign diag_val = -nlr_pkg::sat_q30(nlr_pkg::rnd_shr(prod_reg, 6'd30));
    assign acc_mag  = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign lm_prod  = 11'(l_reg - m_reg) * (11'(l_reg) + 11'(m_reg));
    assign div_num  = m_pos ? ((acc_mag << 16) + 64'(c1_reg >> 1))
                            : (acc_mag + 64'(l_reg >> 1));
    assign quot_signed = neg_reg ? -$signed({32'd0, iter_rsp.root_quot})
                                 : $signed({32'd0, iter_rsp.root_quot});

    nlr_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ANGLES)
    ) u_diag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (m_pos ? diag_val : nlr_pkg::ONE_Q30),
        .re    (accept),
        .raddr (slot_lut[s_angle_index]),
        .rdata (ram_rdata)
    );

    nlr_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .num     (iter_num),
        .den     (iter_den),
        .rsp     (iter_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nlr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nlr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (cfg_err) begin
                        state_next = nlr_pkg::ST_ERR;
                    end else if (order_reg == 5'd0) begin
                        state_next = nlr_pkg::ST_Z0;
                    end else begin
                        state_next = nlr_pkg::ST_DMU2;
                    end
                end
            end
            nlr_pkg::ST_ERR: if (out_free) state_next = nlr_pkg::ST_IDLE;
            nlr_pkg::ST_Z0:  if (out_free) state_next = nlr_pkg::ST_Z1;
            nlr_pkg::ST_Z1: begin
                if (out_free) begin
                    state_next = (lmax_reg == 5'd1) ? nlr_pkg::ST_IDLE : nlr_pkg::ST_SMA;
                end
            end
            nlr_pkg::ST_DMU2:  state_next = nlr_pkg::ST_DS;
            nlr_pkg::ST_DS:    state_next = nlr_pkg::ST_DQ;
            nlr_pkg::ST_DQ:    state_next = nlr_pkg::ST_DQ_GO;
            nlr_pkg::ST_DQ_GO: state_next = nlr_pkg::ST_DQ_WT;
            nlr_pkg::ST_DQ_WT: if (iter_rsp.done) state_next = nlr_pkg::ST_DR_GO;
            nlr_pkg::ST_DR_GO: state_next = nlr_pkg::ST_DR_WT;
            nlr_pkg::ST_DR_WT: if (iter_rsp.done) state_next = nlr_pkg::ST_DRS;
            nlr_pkg::ST_DRS:   state_next = nlr_pkg::ST_DP2;
            nlr_pkg::ST_DP2:   state_next = nlr_pkg::ST_DC_GO;
            nlr_pkg::ST_DC_GO: state_next = nlr_pkg::ST_DC_WT;
            nlr_pkg::ST_DC_WT: if (iter_rsp.done) state_next = nlr_pkg::ST_DA;
            nlr_pkg::ST_DA:    state_next = nlr_pkg::ST_DA2;
            nlr_pkg::ST_DA2:   state_next = nlr_pkg::ST_DCA;
            nlr_pkg::ST_DCA:   state_next = nlr_pkg::ST_DP1;
            nlr_pkg::ST_DP1:   state_next = nlr_pkg::ST_DE0;
            nlr_pkg::ST_DE0:   if (out_free) state_next = nlr_pkg::ST_DE1;
            nlr_pkg::ST_DE1: begin
                if (out_free) begin
                    state_next = (lmax_reg == m_reg + 5'd1) ? nlr_pkg::ST_IDLE
                                                            : nlr_pkg::ST_SMA;
                end
            end
            nlr_pkg::ST_SMA:  state_next = nlr_pkg::ST_SA;
            nlr_pkg::ST_SA:   state_next = nlr_pkg::ST_SKA;
            nlr_pkg::ST_SKA:  state_next = nlr_pkg::ST_SC2;
            nlr_pkg::ST_SC2:  state_next = nlr_pkg::ST_SNUM;
            nlr_pkg::ST_SNUM: begin
                state_next = m_pos ? nlr_pkg::ST_SC1_GO : nlr_pkg::ST_SDIV_GO;
            end
            nlr_pkg::ST_SC1_GO:  state_next = nlr_pkg::ST_SC1_WT;
            nlr_pkg::ST_SC1_WT:  if (iter_rsp.done) state_next = nlr_pkg::ST_SDIV_GO;
            nlr_pkg::ST_SDIV_GO: state_next = nlr_pkg::ST_SDIV_WT;
            nlr_pkg::ST_SDIV_WT: if (iter_rsp.done) state_next = nlr_pkg::ST_SEMIT;
            nlr_pkg::ST_SEMIT: begin
                if (out_free) begin
                    state_next = (l_reg == lmax_reg) ? nlr_pkg::ST_IDLE : nlr_pkg::ST_SMA;
                end
            end
            default: state_next = nlr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a         = mu_reg;
        mul_b         = p1_reg;
        mul_en        = 1'b0;
        iter_req      = '0;
        iter_num      = 64'd0;
        iter_den      = 32'd0;
        ram_we        = 1'b0;
        emit          = 1'b0;
        emit_degree   = l_reg;
        emit_value    = acc_reg[31:0];
        emit_last     = 1'b0;
        emit_error    = 1'b0;
        case (state_reg)
            nlr_pkg::ST_ERR: begin
                emit        = 1'b1;
                emit_degree = 5'd0;
                emit_value  = 32'sd0;
                emit_last   = 1'b1;
                emit_error  = 1'b1;
            end
            nlr_pkg::ST_Z0: begin
                emit        = 1'b1;
                emit_degree = 5'd0;
                emit_value  = nlr_pkg::ONE_Q30;
                ram_we      = 1'b1;
            end
            nlr_pkg::ST_Z1: begin
                emit        = 1'b1;
                emit_degree = 5'd1;
                emit_value  = p1_reg;
                emit_last   = (lmax_reg == 5'd1);
            end
            nlr_pkg::ST_DMU2: begin
                mul_b  = mu_reg;
                mul_en = 1'b1;
            end
            nlr_pkg::ST_DQ: begin
                mul_a  = acc_reg[31:0];
                mul_b  = 32'({m_reg, 1'b0} - 6'd1);
                mul_en = 1'b1;
            end
            nlr_pkg::ST_DQ_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = nlr_pkg::ITER_DIV;
                iter_num       = 64'(prod_reg);
                iter_den       = 32'({m_reg, 1'b0});
            end
            nlr_pkg::ST_DR_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = nlr_pkg::ITER_SQRT;
                iter_num       = {4'd0, acc_reg[29:0], 30'd0};
            end
            nlr_pkg::ST_DRS: begin
                mul_a  = acc_reg[31:0];
                mul_b  = stored_reg;
                mul_en = 1'b1;
            end
            nlr_pkg::ST_DP2: ram_we = 1'b1;
            nlr_pkg::ST_DC_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = nlr_pkg::ITER_SQRT;
                iter_num       = 64'({m_reg, 1'b1}) << 32;
            end
            nlr_pkg::ST_DA: begin
                mul_b  = p2_reg;
                mul_en = 1'b1;
            end
            nlr_pkg::ST_DCA: begin
                mul_a  = c2_reg;
                mul_b  = acc_reg[31:0];
                mul_en = 1'b1;
            end
            nlr_pkg::ST_DE0: begin
                emit        = 1'b1;
                emit_degree = m_reg;
                emit_value  = p2_reg;
            end
            nlr_pkg::ST_DE1: begin
                emit        = 1'b1;
                emit_degree = m_reg + 5'd1;
                emit_value  = p1_reg;
                emit_last   = (lmax_reg == m_reg + 5'd1);
            end
            nlr_pkg::ST_SMA: mul_en = 1'b1;
            nlr_pkg::ST_SKA: begin
                mul_a  = acc_reg[31:0];
                mul_b  = 32'({l_reg, 1'b0} - 6'd1);
                mul_en = 1'b1;
            end
            nlr_pkg::ST_SC2: begin
                mul_a  = m_pos ? c2_reg : 32'(l_reg - 5'd1);
                mul_b  = p2_reg;
                mul_en = 1'b1;
            end
            nlr_pkg::ST_SC1_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = nlr_pkg::ITER_SQRT;
                iter_num       = 64'(lm_prod) << 32;
            end
            nlr_pkg::ST_SDIV_GO: begin
                iter_req.start = 1'b1;
                iter_req.mode  = nlr_pkg::ITER_DIV;
                iter_num       = div_num;
                iter_den       = m_pos ? c1_reg : 32'(l_reg);
            end
            nlr_pkg::ST_SEMIT: begin
                emit      = 1'b1;
                emit_last = (l_reg == lmax_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_prod;
        end
        case (state_reg)
            nlr_pkg::ST_IDLE: begin
                if (accept) begin
                    mu_reg   <= mu_clamped;
                    p1_reg   <= mu_clamped;
                    p2_reg   <= nlr_pkg::ONE_Q30;
                    slot_reg <= slot_lut[s_angle_index];
                    m_reg    <= order_reg;
                    lmax_reg <= lmax_cfg;
                end
            end
            nlr_pkg::ST_Z1:    if (out_free) l_reg <= 5'd2;
            nlr_pkg::ST_DMU2:  stored_reg <= ram_rdata;
            nlr_pkg::ST_DS: begin
                acc_reg <= 64'(nlr_pkg::ONE_Q30) - nlr_pkg::rnd_shr(prod_reg, 6'd30);
            end
            nlr_pkg::ST_DQ_WT: if (iter_rsp.done) acc_reg <= {32'd0, iter_rsp.root_quot};
            nlr_pkg::ST_DR_WT: if (iter_rsp.done) acc_reg <= {32'd0, iter_rsp.root_quot};
            nlr_pkg::ST_DP2:   p2_reg <= diag_val;
            nlr_pkg::ST_DC_WT: if (iter_rsp.done) c2_reg <= iter_rsp.root_quot;
            nlr_pkg::ST_DA2:   acc_reg <= nlr_pkg::rnd_shr(prod_reg, 6'd30);
            nlr_pkg::ST_DP1: begin
                p1_reg <= nlr_pkg::sat_q30(nlr_pkg::rnd_shr(prod_reg, 6'd16));
            end
            nlr_pkg::ST_DE1:   if (out_free) l_reg <= m_reg + 5'd2;
            nlr_pkg::ST_SA:    acc_reg <= nlr_pkg::rnd_shr(prod_reg, 6'd30);
            nlr_pkg::ST_SC2:   acc_reg <= prod_reg;
            nlr_pkg::ST_SNUM: begin
                acc_reg <= acc_reg - (m_pos ? nlr_pkg::rnd_shr(prod_reg, 6'd16) : prod_reg);
            end
            nlr_pkg::ST_SC1_WT:  if (iter_rsp.done) c1_reg <= iter_rsp.root_quot;
            nlr_pkg::ST_SDIV_GO: neg_reg <= acc_reg[63];
            nlr_pkg::ST_SDIV_WT: begin
                if (iter_rsp.done) begin
                    acc_reg <= 64'(nlr_pkg::sat_q30(quot_signed));
                end
            end
            nlr_pkg::ST_SEMIT: begin
                if (out_free) begin
                    p2_reg <= p1_reg;
                    p1_reg <= acc_reg[31:0];
                    c2_reg <= c1_reg;
                    l_reg  <= l_reg + 5'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit && out_free) begin
            m_degree_reg     <= emit_degree;
            m_poly_value_reg <= emit_value;
            m_last_reg       <= emit_last;
            m_error_reg      <= emit_error;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_degree     = m_degree_reg;
    assign m_poly_value = m_poly_value_reg;
    assign m_last       = m_last_reg;
    assign m_error      = m_error_reg;

endmodule

@@ sv/nlr_checker.sv @@
// ----------------------------------------------------------------------------
// nlr_checker
// Port-level checks for the normalized Legendre recurrence block.
// ----------------------------------------------------------------------------
module nlr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [4:0]         m_degree,
    input logic signed [31:0] m_poly_value,
    input logic               m_last,
    input logic               m_error
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an angle is in flight");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_poly_value) && $stable(m_degree))
        else $error("stalled result transaction changed");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_last && m_degree == 5'd0 && m_poly_value == 32'sd0)
        else $error("error transaction malformed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_poly_value <= 32'sd1073741824 && m_poly_value >= -32'sd1073741824)
        else $error("value outside saturation range");

endmodule

bind normalized_legendre_recurrence_top nlr_checker u_nlr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_degree     (m_degree),
    .m_poly_value (m_poly_value),
    .m_last       (m_last),
    .m_error      (m_error)
);

@@ test/nlr_checker.sv @@
// ----------------------------------------------------------------------------
// nlr_scoreboard
// Watches the APB port and both streams of the Legendre recurrence block,
// predicts every result from its own copy of the registers and the diagonal
// store, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module nlr_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [5:0]         s_angle_index,
    input  logic signed [31:0] s_angle_cosine,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [4:0]         m_degree,
    input  logic signed [31:0] m_poly_value,
    input  logic               m_last,
    input  logic               m_error,
    output int                 fail_count,
    output int                 pending
);

    localparam longint Q30_ONE = 64'sd1073741824;

    typedef struct {
        logic [4:0]  degree;
        logic [31:0] value;
        logic        last;
        logic        error;
    } legendre_result_t;

    legendre_result_t expected_values[$];
    logic [4:0]       az_order;
    logic [4:0]       top_degree;
    logic [31:0]      diag_mem [64];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint n, input longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = (mag + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_shift(input longint v, input int sh);
        return round_div(v, 64'd1 << sh);
    endfunction

    function automatic longint clamp_q30(input longint v);
        if (v > Q30_ONE) return Q30_ONE;
        if (v < -Q30_ONE) return -Q30_ONE;
        return v;
    endfunction

    function automatic void push_value(input longint l, input longint v, input bit fin,
                                       input bit err);
        legendre_result_t r;
        r.degree = l[4:0];
        r.value  = v[31:0];
        r.last   = fin;
        r.error  = err;
        expected_values.push_back(r);
    endfunction

    task automatic predict_angle(input logic [5:0] slot, input logic signed [31:0] cosv);
        longint m, lmax, l, mu, p2, p1, v, a, num, s, r, c, c2, stored;
        longint unsigned q, c1;
        m = az_order;
        lmax = (top_degree > nlr_pkg::MAX_DEGREE) ? nlr_pkg::MAX_DEGREE : top_degree;
        mu = clamp_q30(longint'(cosv));
        if (m + 1 > lmax) begin
            push_value(0, 0, 1'b1, 1'b1);
            return;
        end
        if (m == 0) begin
            diag_mem[slot] = nlr_pkg::ONE_Q30;
            p2 = Q30_ONE;
            p1 = mu;
            push_value(0, p2, 1'b0, 1'b0);
            push_value(1, p1, lmax == 1, 1'b0);
            for (l = 2; l <= lmax; l++) begin
                a = round_shift(mu * p1, 30);
                num = (2 * l - 1) * a - (l - 1) * p2;
                v = clamp_q30(round_div(num, l));
                push_value(l, v, l == lmax, 1'b0);
                p2 = p1;
                p1 = v;
            end
            return;
        end
        s = Q30_ONE - round_shift(mu * mu, 30);
        q = (longint'(s) * (2 * m - 1)) / (2 * m);
        r = int_sqrt(q << 30);
        stored = longint'(signed'(diag_mem[slot]));
        c = int_sqrt(longint'(2 * m + 1) << 32);
        p2 = -clamp_q30(round_shift(r * stored, 30));
        diag_mem[slot] = p2[31:0];
        p1 = clamp_q30(round_shift(c * round_shift(mu * p2, 30), 16));
        push_value(m, p2, 1'b0, 1'b0);
        push_value(m + 1, p1, lmax == m + 1, 1'b0);
        for (l = m + 2; l <= lmax; l++) begin
            c1 = int_sqrt(longint'((l - m) * (l + m)) << 32);
            c2 = int_sqrt(longint'((l - m - 1) * (l + m - 1)) << 32);
            a = round_shift(mu * p1, 30);
            num = (2 * l - 1) * a - round_shift(c2 * p2, 16);
            v = clamp_q30(round_div(num * 65536, c1));
            push_value(l, v, l == lmax, 1'b0);
            p2 = p1;
            p1 = v;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        az_order = 0;
        top_degree = 31;
    end

    always @(posedge aclk) begin
        legendre_result_t e;
        if (!aresetn) begin
            az_order <= 0;
            top_degree <= 31;
            expected_values.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {nlr_pkg::REG_ORDER, 2'b00}) az_order <= pwdata[4:0];
                else if (paddr == {nlr_pkg::REG_MAX_DEGREE, 2'b00})
                    top_degree <= pwdata[4:0];
            end
            if (s_valid && s_ready) predict_angle(s_angle_index, s_angle_cosine);
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: degree %0d value %0d",
                                 m_degree, m_poly_value);
                end else begin
                    e = expected_values.pop_front();
                    if (m_degree !== e.degree || m_poly_value !== e.value
                            || m_last !== e.last || m_error !== e.error) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: expected deg %0d val %0d last %0d ",
                                      "err %0d, got deg %0d val %0d last %0d err %0d"},
                                     e.degree, $signed(e.value), e.last, e.error, m_degree,
                                     m_poly_value, m_last, m_error);
                    end
                end
            end
        end
        pending = expected_values.size();
    end

endmodule

@@ test/tb_normalized_legendre_recurrence_top.sv @@
// ----------------------------------------------------------------------------
// tb_normalized_legendre_recurrence_top
// Drives angle transactions and register settings into the Legendre
// recurrence block under random idling on both streams, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_normalized_legendre_recurrence_top;

    localparam int STALL_LIMIT = 20000;

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               s_valid, s_ready;
    logic [5:0]         s_angle_index;
    logic signed [31:0] s_angle_cosine;
    logic               m_valid, m_ready;
    logic [4:0]         m_degree;
    logic signed [31:0] m_poly_value;
    logic               m_last, m_error;

    int       fail_count, pending;
    int       tx_idle_pct, rx_idle_pct;
    int       sent_count;
    int       quiet_cycles;
    bit       hold_request;
    bit [4:0] cur_order;
    bit [4:0] cur_degree;
    bit [63:0] slot_written;

    normalized_legendre_recurrence_top DUT (.*);

    nlr_scoreboard u_checker (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_angle_index = 0; s_angle_cosine = 0; m_ready = 0;
        tx_idle_pct = 24; rx_idle_pct = 83; sent_count = 0; hold_request = 0;
        slot_written = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int k;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                for (k = 0; k < 400; k++) begin
                    m_ready <= 0;
                    @(negedge aclk);
                end
                hold_request = 0;
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("normalized_legendre_recurrence_top: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        wait (pending == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic configure(input bit [4:0] ord, input bit [4:0] deg);
        drain();
        reg_write({nlr_pkg::REG_ORDER, 2'b00},
                  {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, ord});
        reg_write({nlr_pkg::REG_MAX_DEGREE, 2'b00}, {27'h0, deg});
        cur_order = ord;
        cur_degree = deg;
    endtask

    task automatic send_angle(input logic [5:0] slot, input logic signed [31:0] cosv);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_angle_index <= slot;
        s_angle_cosine <= cosv;
        if (cur_order == 0 && cur_order + 1 <= cur_degree) slot_written[slot] = 1;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (sent_count == 85) begin
            tx_idle_pct = 83; rx_idle_pct = 24;
        end else if (sent_count == 170) begin
            tx_idle_pct = 0; rx_idle_pct = 0;
        end
    endtask

    function automatic logic [5:0] pick_slot();
        logic [5:0] s;
        s = $urandom_range(0, 63);
        if (cur_order != 0 && cur_order + 1 <= cur_degree) begin
            while (!slot_written[s]) s = $urandom_range(0, 63);
        end
        return s;
    endfunction

    function automatic logic signed [31:0] pick_cosine();
        if ($urandom_range(0, 99) < 15) return $urandom;
        return int'($urandom_range(32'h8000_0000, 0)) - 32'sd1073741824;
    endfunction

    task automatic random_phase(input bit [4:0] ord, input bit [4:0] deg, input int n);
        int i;
        configure(ord, deg);
        for (i = 0; i < n; i++) begin
            if (i == n / 2 && ord == 2) hold_request = 1;
            send_angle(pick_slot(), pick_cosine());
        end
    endtask

    initial begin
        @(posedge aresetn);
        // directed: cosine extremes at full degree range, order 0
        configure(0, 31);
        send_angle(6'd0, nlr_pkg::ONE_Q30);
        send_angle(6'd63, nlr_pkg::NEG_ONE_Q30);
        send_angle(6'd1, 32'sd0);
        send_angle(6'd2, 32'sh7fff_ffff);
        send_angle(6'd3, 32'sh8000_0000);
        send_angle(6'd4, 32'sd536870912);
        configure(0, 1);
        send_angle(6'd5, 32'sd123456789);
        send_angle(6'd6, -32'sd987654321);
        configure(30, 31);
        send_angle(6'd0, 32'sd0);
        send_angle(6'd63, nlr_pkg::ONE_Q30);
        send_angle(6'd3, 32'sd1000);
        configure(1, 31);
        send_angle(6'd1, 32'sd700000000);
        send_angle(6'd2, nlr_pkg::NEG_ONE_Q30);
        configure(5, 3);
        send_angle(6'd4, 32'sd5);
        send_angle(6'd63, 32'sh7fff_ffff);
        configure(31, 31);
        send_angle(6'd7, 32'sd0);
        // random phases
        random_phase(0, 3, 50);
        random_phase(1, 4, 35);
        random_phase(2, 6, 30);
        random_phase(7, 5, 10);
        random_phase(0, 1, 30);
        random_phase(3, 9, 30);
        random_phase(29, 31, 20);
        random_phase(0, 12, 15);
        random_phase(4, 8, 30);
        drain();
        if (fail_count == 0) begin
            $display("normalized_legendre_recurrence_top: match");
        end else begin
            $display("normalized_legendre_recurrence_top: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/nlr_pkg.sv
sv/nlr_ram.sv
sv/nlr_iter.sv
sv/normalized_legendre_recurrence_top.sv
sv/nlr_checker.sv
test/nlr_checker.sv
test/tb_normalized_legendre_recurrence_top.sv
